// ===== hdl/weighted_round_robin_class_queues_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the weighted round robin class queues
// Implication and next-cycle implication checks, clocked and reset-disabled.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_ROUND_ROBIN_CLASS_QUEUES_ASSERT_SVH
`define WEIGHTED_ROUND_ROBIN_CLASS_QUEUES_ASSERT_SVH

// same-cycle implication
`define WRR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wrr assertion failed: same-cycle implication");

// next-cycle implication
`define WRR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wrr assertion failed: next-cycle implication");

`endif

// ===== hdl/wrr_pkg.sv =====
// ---------------------------------------------------------------------------
// wrr_pkg
// Shared types and codes of the weighted round robin class queues.
// ---------------------------------------------------------------------------
package wrr_pkg;

	// field widths
	localparam int ACCT_W    = 31;
	localparam int OPS_W     = 16;
	localparam int CLS_IN_W  = 3;
	localparam int STATUS_W  = 3;
	localparam int TIME_W    = 24;
	localparam int WAIT_W    = 9;
	localparam int REG_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 88;

	// number of programmable class weights
	localparam int WEIGHT_REGS = 5;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ENQ   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DEQ   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT1   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT2   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT3   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT4   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT5   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_UNIT = 3'd5;

	// function codes
	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic accept;   // latch the incoming item
		logic exec;     // update queues, credits, issue store access
		logic emit;     // load the result register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free; // result register can take a new item
	} stat_t;

endpackage

// ===== hdl/weighted_round_robin_class_queues.sv =====
// ---------------------------------------------------------------------------
// weighted_round_robin_class_queues
// Weighted round robin scheduler over per-class request FIFOs.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser is the function (enqueue / dequeue),
//   tdata the class, account and op count. m_axis returns one result item
//   per request: tuser is the status, tdata the granted class, account, op
//   count, service time and the number of requests still waiting.
//   cfg_we/cfg_index/cfg_wdata write the five class weights and the time
//   unit; write only while no request is in flight.
//   Flow: the request is accepted, then an execute step does the queue
//   pointer, credit and store access, then the emit step loads the result
//   register; the next request is taken in the cycle the result register
//   is loaded, so accept and emit overlap.
//   A stalled m_axis holds the result; the block finishes the item in
//   flight and then waits with s_axis_tready low until the result drains.
//   Reset empties all queues, sets weights, credits and time unit to one.
//   The request store holds no reset value and needs no clearing pass.
// ---------------------------------------------------------------------------
module weighted_round_robin_class_queues #(
	parameter int QUEUE_DEPTH = 64,
	parameter int CLASS_COUNT = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [2:0] req_class, [33:3] account, [49:34] op_count, zero pad above
	input  logic [wrr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [0] func
	input  logic                               s_axis_tuser,
	// result channel
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [2:0] granted_class, [33:3] granted_account, [49:34] granted_ops,
	// [73:50] service_time, [82:74] waiting_total, zero pad above
	output logic [wrr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// [2:0] status
	output logic [wrr_pkg::STATUS_W-1:0]       m_axis_tuser,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [wrr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wrr_pkg::REG_W-1:0]          cfg_wdata
);

	wrr_pkg::cmd_t  cmd;
	wrr_pkg::stat_t stat;

	wrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	wrr_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CLASS_COUNT (CLASS_COUNT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_data    (s_axis_tdata),
		.in_func    (s_axis_tuser),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_status (m_axis_tuser)
	);

	// checks
	`include "weighted_round_robin_class_queues_assert.svh"

	// an accepted item is executed in the following cycle
	`WRR_ASSERT_NXT(a_accept_exec, clk, arst_n, cmd.accept, cmd.exec && !s_axis_tready)
	// a result is never loaded over one still waiting
	`WRR_ASSERT_IMP(a_emit_free, clk, arst_n, cmd.emit, stat.out_free)
	// a loaded result is presented next cycle
	`WRR_ASSERT_NXT(a_emit_valid, clk, arst_n, cmd.emit, m_axis_tvalid)

endmodule

// ===== hdl/wrr_ctrl.sv =====
// ---------------------------------------------------------------------------
// wrr_ctrl
// Sequencer: accept, execute, emit; overlaps the next accept with emit.
// ---------------------------------------------------------------------------
module wrr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  wrr_pkg::stat_t stat,
	output wrr_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.exec   = 1'b0;
		cmd.emit   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				// hold until the result slot drains
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.accept = 1'b1;
						state_d    = S_EXEC;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/wrr_datapath.sv =====
// ---------------------------------------------------------------------------
// wrr_datapath
// Class FIFOs in one store, credit bookkeeping, config and result register.
// ---------------------------------------------------------------------------
module wrr_datapath #(
	parameter int QUEUE_DEPTH = 64,
	parameter int CLASS_COUNT = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wrr_pkg::cmd_t                       cmd,
	output wrr_pkg::stat_t                      stat,
	input  logic                                cfg_we,
	input  logic [wrr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wrr_pkg::REG_W-1:0]           cfg_wdata,
	input  logic [wrr_pkg::IN_DATA_W-1:0]       in_data,
	input  logic                                in_func,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [wrr_pkg::OUT_DATA_W-1:0]      out_data,
	output logic [wrr_pkg::STATUS_W-1:0]        out_status
);

	localparam int IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int CLS_W     = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
	localparam int TOT_W     = $clog2(CLASS_COUNT * QUEUE_DEPTH + 1);
	localparam int MEM_DEPTH = CLASS_COUNT << IDX_W;
	localparam int ADDR_W    = CLS_W + IDX_W;
	localparam int ENTRY_W   = wrr_pkg::OPS_W + wrr_pkg::ACCT_W;

	// input item latch
	logic                           func_q;
	logic [wrr_pkg::CLS_IN_W-1:0]   cls_q;
	logic [wrr_pkg::ACCT_W-1:0]     acct_q;
	logic [wrr_pkg::OPS_W-1:0]      ops_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= in_func;
			cls_q  <= in_data[wrr_pkg::CLS_IN_W-1:0];
			acct_q <= in_data[wrr_pkg::CLS_IN_W +: wrr_pkg::ACCT_W];
			ops_q  <= in_data[wrr_pkg::CLS_IN_W + wrr_pkg::ACCT_W +: wrr_pkg::OPS_W];
		end
	end

	// configuration registers
	logic [wrr_pkg::REG_W-1:0] weight_q [wrr_pkg::WEIGHT_REGS];
	logic [wrr_pkg::REG_W-1:0] time_unit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wrr_pkg::WEIGHT_REGS; i++) begin
				weight_q[i] <= 8'd1;
			end
			time_unit_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index) inside
				wrr_pkg::CFG_WEIGHT1, wrr_pkg::CFG_WEIGHT2, wrr_pkg::CFG_WEIGHT3,
				wrr_pkg::CFG_WEIGHT4, wrr_pkg::CFG_WEIGHT5: begin
					weight_q[cfg_index] <= cfg_wdata;
				end
				wrr_pkg::CFG_TIME_UNIT: time_unit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// per-class weight, fixed at one above the programmable classes
	logic [wrr_pkg::REG_W-1:0] class_w [CLASS_COUNT];

	for (genvar c = 0; c < CLASS_COUNT; c++) begin : g_weight
		if (c < wrr_pkg::WEIGHT_REGS) begin : g_reg
			assign class_w[c] = weight_q[c];
		end else begin : g_fixed
			assign class_w[c] = 8'd1;
		end
	end

	// queue state
	logic [IDX_W-1:0]          head_q   [CLASS_COUNT];
	logic [IDX_W-1:0]          tail_q   [CLASS_COUNT];
	logic [CNT_W-1:0]          count_q  [CLASS_COUNT];
	logic [wrr_pkg::REG_W-1:0] credit_q [CLASS_COUNT];
	logic [TOT_W-1:0]          total_q;

	// grant scan: first with credit, else first with a reloadable weight
	logic [CLASS_COUNT-1:0] nonempty, has_credit, has_weight;
	logic                   any1, any2, grant;
	logic [CLS_W-1:0]       sel1, sel2, deq_sel;

	always_comb begin
		any1 = 1'b0;
		any2 = 1'b0;
		sel1 = '0;
		sel2 = '0;
		for (int c = 0; c < CLASS_COUNT; c++) begin
			nonempty[c]   = (count_q[c] != '0);
			has_credit[c] = (credit_q[c] != '0);
			has_weight[c] = (class_w[c] != '0);
		end
		for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
			if (nonempty[c] && has_credit[c]) begin
				any1 = 1'b1;
				sel1 = CLS_W'(c);
			end
			if (nonempty[c] && has_weight[c]) begin
				any2 = 1'b1;
				sel2 = CLS_W'(c);
			end
		end
		grant   = any1 || any2;
		deq_sel = any1 ? sel1 : sel2;
	end

	// enqueue checks
	logic             cls_ok, enq_ok, enq_full;
	logic [CLS_W-1:0] enq_sel, sel_cls;
	logic [IDX_W-1:0] sel_head, sel_tail;
	logic [CNT_W-1:0] sel_count;

	assign cls_ok  = (cls_q != '0) && ({29'd0, cls_q} <= 32'(CLASS_COUNT));
	assign enq_sel = CLS_W'(cls_q - 3'd1);
	assign sel_cls = (func_q == wrr_pkg::FUNC_DEQ) ? deq_sel : enq_sel;

	always_comb begin
		sel_head  = '0;
		sel_tail  = '0;
		sel_count = '0;
		for (int c = 0; c < CLASS_COUNT; c++) begin
			if (sel_cls == CLS_W'(c)) begin
				sel_head  = head_q[c];
				sel_tail  = tail_q[c];
				sel_count = count_q[c];
			end
		end
	end

	assign enq_full = (sel_count == CNT_W'(QUEUE_DEPTH));
	assign enq_ok   = (func_q == wrr_pkg::FUNC_ENQ) && cls_ok && !enq_full;

	logic do_deq;
	assign do_deq = (func_q == wrr_pkg::FUNC_DEQ) && grant;

	// state update on execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CLASS_COUNT; c++) begin
				head_q[c]   <= '0;
				tail_q[c]   <= '0;
				count_q[c]  <= '0;
				credit_q[c] <= 8'd1;
			end
			total_q <= '0;
		end else if (cmd.exec) begin
			for (int c = 0; c < CLASS_COUNT; c++) begin
				if (enq_ok && sel_cls == CLS_W'(c)) begin
					tail_q[c]  <= (tail_q[c] == IDX_W'(QUEUE_DEPTH - 1)) ?
						'0 : tail_q[c] + 1'b1;
					count_q[c] <= count_q[c] + 1'b1;
				end
				if (do_deq && sel_cls == CLS_W'(c)) begin
					head_q[c]   <= (head_q[c] == IDX_W'(QUEUE_DEPTH - 1)) ?
						'0 : head_q[c] + 1'b1;
					count_q[c]  <= count_q[c] - 1'b1;
					// granted class: reloaded first when the round restarts
					credit_q[c] <= (any1 ? credit_q[c] : class_w[c]) - 1'b1;
				end else if (func_q == wrr_pkg::FUNC_DEQ && !any1 &&
					nonempty[c] && has_weight[c]) begin
					credit_q[c] <= class_w[c];
				end
			end
			if (enq_ok) begin
				total_q <= total_q + 1'b1;
			end else if (do_deq) begin
				total_q <= total_q - 1'b1;
			end
		end
	end

	// request store, one write and one registered read port
	logic [ENTRY_W-1:0] store_mem [0:MEM_DEPTH-1];
	logic [ENTRY_W-1:0] rd_entry_q;

	always_ff @(posedge clk) begin
		if (cmd.exec && enq_ok) begin
			store_mem[ADDR_W'({sel_cls, sel_tail})] <= {ops_q, acct_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && do_deq) begin
			rd_entry_q <= store_mem[ADDR_W'({sel_cls, sel_head})];
		end
	end

	// execute outcome
	logic [wrr_pkg::STATUS_W-1:0] status_q;
	logic [CLS_W-1:0]             gcls_q;
	logic                         grant_q;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			gcls_q  <= deq_sel;
			grant_q <= do_deq;
			if (func_q == wrr_pkg::FUNC_DEQ) begin
				status_q <= grant ? wrr_pkg::ST_DEQ : wrr_pkg::ST_EMPTY;
			end else if (!cls_ok) begin
				status_q <= wrr_pkg::ST_BAD;
			end else if (enq_full) begin
				status_q <= wrr_pkg::ST_FULL;
			end else begin
				status_q <= wrr_pkg::ST_ENQ;
			end
		end
	end

	// result fields
	logic [wrr_pkg::CLS_IN_W-1:0] res_cls;
	logic [wrr_pkg::ACCT_W-1:0]   res_acct;
	logic [wrr_pkg::OPS_W-1:0]    res_ops;
	logic [wrr_pkg::TIME_W-1:0]   res_time;

	always_comb begin
		res_cls  = '0;
		res_acct = '0;
		res_ops  = '0;
		res_time = '0;
		if (grant_q) begin
			res_cls  = wrr_pkg::CLS_IN_W'({1'b0, gcls_q} + 1'b1);
			res_acct = rd_entry_q[wrr_pkg::ACCT_W-1:0];
			res_ops  = rd_entry_q[wrr_pkg::ACCT_W +: wrr_pkg::OPS_W];
			res_time = wrr_pkg::TIME_W'(res_ops) * wrr_pkg::TIME_W'(time_unit_q);
		end
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status <= status_q;
			out_data   <= {5'd0, wrr_pkg::WAIT_W'(total_q), res_time, res_ops,
				res_acct, res_cls};
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule
